[sv/dufe_pkg.sv]
// ----------------------------------------------------------------------------
// Dual union-find equivalence package
// Shared constants and the operation codes of the request word.
// ----------------------------------------------------------------------------
package dufe_pkg;

   localparam int ID_W          = 8;
   localparam int RANK_W        = 4;
   localparam int NODES_DEF     = 256;
   localparam int MAX_EDGES_DEF = 1024;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_FIRST  = 2'd1,
      OP_SECOND = 2'd2,
      OP_FINISH = 2'd3
   } op_type;

endpackage

[sv/dual_union_find_equivalence.sv]
// A clear writes every node of both forests. An edge is stored while the edge store has room;
// in each forest it visits, root searches with path compression find both endpoint roots,
// which are compared or linked by rank. A finish repeats the searches and compare per stored edge.
// Throughput: one word at a time; req_stall stays high until the word is done.
// Reset: a clearing pass rebuilds both forests; req_stall stays high until it is done.
// ----------------------------------------------------------------------------
// Dual union-find equivalence checker
// Two disjoint-set forests with union by rank and path compression, walked by
// one sequencer through the two forest memories and an edge store.
// ----------------------------------------------------------------------------
module dual_union_find_equivalence
   import dufe_pkg::*;
#(
   parameter int NODES     = NODES_DEF,
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [1:0]      req_operation,
   input  logic [ID_W-1:0] req_node_a,
   input  logic [ID_W-1:0] req_node_b,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic            rsp_equivalent,
   output logic            rsp_is_verdict,
   output logic            rsp_overflow
);

   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int WORD_W = RANK_W + NODE_W;
   localparam int CNT_W  = $clog2(MAX_EDGES + 1);
   localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_W = 2 * NODE_W;

   typedef enum logic [10:0] {
      ST_CLEAR     = 11'b00000000001,
      ST_IDLE      = 11'b00000000010,
      ST_FIND_RD   = 11'b00000000100,
      ST_FIND_CHK  = 11'b00000001000,
      ST_COMP_RD   = 11'b00000010000,
      ST_COMP_CHK  = 11'b00000100000,
      ST_PAIR      = 11'b00001000000,
      ST_LINK_RANK = 11'b00010000000,
      ST_EDGE_RD   = 11'b00100000000,
      ST_EDGE_LD   = 11'b01000000000,
      ST_DONE      = 11'b10000000000
   } state_type;

   function automatic logic [NODE_W-1:0] reduce_id(input logic [ID_W-1:0] id);
      logic [31:0] t;
      t = 32'(id);
      for (int k = ID_W - 1; k >= 0; k--) begin
         if (t >= (32'(NODES) << k)) begin
            t = t - (32'(NODES) << k);
         end
      end
      return t[NODE_W-1:0];
   endfunction

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [NODE_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic [NODE_W-1:0]   start_ff, start_in, cur_ff, cur_in, root_ff, root_in;
   logic [NODE_W-1:0]   u_ff, u_in, v_ff, v_in;
   logic [RANK_W-1:0]   rr_ff, rr_in, ru_ff, ru_in, rv_ff, rv_in;
   logic                sel_ff, sel_in, fidx_ff, fidx_in, check_ff, check_in;
   logic                eq_ff, eq_in, mismatch_ff, mismatch_in, ovf_ff, ovf_in;
   logic [CNT_W-1:0]    count_ff, count_in, idx_ff, idx_in;
   logic [NODE_W-1:0]   clr_ptr_ff, clr_ptr_in;
   logic                clr_rsp_ff, clr_rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_eq_ff, rsp_eq_in, rsp_verdict_ff, rsp_verdict_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic [WORD_W-1:0]   forest0_mem [0:NODES-1];
   logic [WORD_W-1:0]   forest1_mem [0:NODES-1];
   logic [WORD_W-1:0]   rdata0_ff, rdata1_ff;
   logic [EDGE_W-1:0]   edge_mem [0:MAX_EDGES-1];
   logic [EDGE_W-1:0]   edata_ff;

   logic                wr_en, wr_all, wr_en0, wr_en1;
   logic [NODE_W-1:0]   wr_addr;
   logic [WORD_W-1:0]   wr_data;
   logic                ewr_en;
   logic [EDGE_W-1:0]   ewr_data;

   logic [WORD_W-1:0]   rword;
   logic [NODE_W-1:0]   rparent;
   logic [RANK_W-1:0]   rrank;
   logic [NODE_W-1:0]   a_red, b_red, ea, eb;
   logic                accept;
   op_type              req_op;

   assign req_op    = op_type'(req_operation);
   assign a_red     = reduce_id(req_node_a);
   assign b_red     = reduce_id(req_node_b);
   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign rword     = sel_ff ? rdata1_ff : rdata0_ff;
   assign rparent   = rword[NODE_W-1:0];
   assign rrank     = rword[WORD_W-1:NODE_W];
   assign ea        = edata_ff[EDGE_W-1:NODE_W];
   assign eb        = edata_ff[NODE_W-1:0];
   assign wr_en0    = wr_en && (wr_all || !sel_ff);
   assign wr_en1    = wr_en && (wr_all || sel_ff);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      start_in       = start_ff;
      cur_in         = cur_ff;
      root_in        = root_ff;
      u_in           = u_ff;
      v_in           = v_ff;
      rr_in          = rr_ff;
      ru_in          = ru_ff;
      rv_in          = rv_ff;
      sel_in         = sel_ff;
      fidx_in        = fidx_ff;
      check_in       = check_ff;
      eq_in          = eq_ff;
      mismatch_in    = mismatch_ff;
      ovf_in         = ovf_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      clr_ptr_in     = clr_ptr_ff;
      clr_rsp_in     = clr_rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_eq_in      = rsp_eq_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      wr_en          = 1'b0;
      wr_all         = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = {rrank, root_ff};
      ewr_en         = 1'b0;
      ewr_data       = {a_red, b_red};

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_all  = 1'b1;
            wr_addr = clr_ptr_ff;
            wr_data = {RANK_W'(0), clr_ptr_ff};
            if (clr_ptr_ff == NODE_W'(NODES - 1)) begin
               state_in   = clr_rsp_ff ? ST_DONE : ST_IDLE;
               clr_rsp_in = 1'b0;
            end else begin
               clr_ptr_in = clr_ptr_ff + NODE_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               x_in     = a_red;
               y_in     = b_red;
               start_in = a_red;
               cur_in   = a_red;
               fidx_in  = 1'b0;
               eq_in    = 1'b1;
               case (req_op)
                  OP_CLEAR: begin
                     count_in    = '0;
                     mismatch_in = 1'b0;
                     ovf_in      = 1'b0;
                     clr_ptr_in  = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  OP_FIRST: begin
                     if (count_ff < CNT_W'(MAX_EDGES)) begin
                        ewr_en   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     sel_in   = 1'b0;
                     check_in = 1'b0;
                     state_in = ST_FIND_RD;
                  end
                  OP_SECOND: begin
                     sel_in   = 1'b0;
                     check_in = 1'b1;
                     state_in = mismatch_ff ? ST_DONE : ST_FIND_RD;
                  end
                  OP_FINISH: begin
                     idx_in   = '0;
                     sel_in   = 1'b1;
                     check_in = 1'b1;
                     if (mismatch_ff || (count_ff == '0)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_EDGE_RD;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            if (rparent == cur_ff) begin
               root_in  = cur_ff;
               rr_in    = rrank;
               cur_in   = start_ff;
               state_in = ST_COMP_RD;
            end else begin
               cur_in   = rparent;
               state_in = ST_FIND_RD;
            end
         end
         ST_COMP_RD: begin
            state_in = ST_COMP_CHK;
         end
         ST_COMP_CHK: begin
            if (rparent == cur_ff) begin
               if (!fidx_ff) begin
                  u_in     = root_ff;
                  ru_in    = rr_ff;
                  fidx_in  = 1'b1;
                  start_in = y_ff;
                  cur_in   = y_ff;
                  state_in = ST_FIND_RD;
               end else begin
                  v_in     = root_ff;
                  rv_in    = rr_ff;
                  state_in = ST_PAIR;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               wr_data  = {rrank, root_ff};
               cur_in   = rparent;
               state_in = ST_COMP_RD;
            end
         end
         ST_PAIR: begin
            if (check_ff) begin
               if (op_ff == OP_SECOND) begin
                  if (u_ff != v_ff) begin
                     mismatch_in = 1'b1;
                  end
                  check_in = 1'b0;
                  sel_in   = 1'b1;
                  fidx_in  = 1'b0;
                  start_in = x_ff;
                  cur_in   = x_ff;
                  state_in = ST_FIND_RD;
               end else if (u_ff != v_ff) begin
                  eq_in    = 1'b0;
                  state_in = ST_DONE;
               end else if ((idx_ff + CNT_W'(1)) == count_ff) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = ST_EDGE_RD;
               end
            end else if (u_ff == v_ff) begin
               state_in = ST_DONE;
            end else if (ru_ff > rv_ff) begin
               wr_en    = 1'b1;
               wr_addr  = v_ff;
               wr_data  = {rv_ff, u_ff};
               state_in = ST_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = u_ff;
               wr_data  = {ru_ff, v_ff};
               state_in = (ru_ff == rv_ff) ? ST_LINK_RANK : ST_DONE;
            end
         end
         ST_LINK_RANK: begin
            wr_en    = 1'b1;
            wr_addr  = v_ff;
            wr_data  = {rv_ff + RANK_W'(1), v_ff};
            state_in = ST_DONE;
         end
         ST_EDGE_RD: begin
            state_in = ST_EDGE_LD;
         end
         ST_EDGE_LD: begin
            x_in     = ea;
            y_in     = eb;
            start_in = ea;
            cur_in   = ea;
            fidx_in  = 1'b0;
            state_in = ST_FIND_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_eq_in      = eq_ff && !mismatch_ff;
               rsp_verdict_in = (op_ff == OP_FINISH);
               rsp_ovf_in     = ovf_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         mismatch_ff  <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         mismatch_ff  <= mismatch_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      start_ff       <= start_in;
      cur_ff         <= cur_in;
      root_ff        <= root_in;
      u_ff           <= u_in;
      v_ff           <= v_in;
      rr_ff          <= rr_in;
      ru_ff          <= ru_in;
      rv_ff          <= rv_in;
      sel_ff         <= sel_in;
      fidx_ff        <= fidx_in;
      check_ff       <= check_in;
      eq_ff          <= eq_in;
      idx_ff         <= idx_in;
      rsp_eq_ff      <= rsp_eq_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en0) begin
         forest0_mem[wr_addr] <= wr_data;
      end
      rdata0_ff <= forest0_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (wr_en1) begin
         forest1_mem[wr_addr] <= wr_data;
      end
      rdata1_ff <= forest1_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (ewr_en) begin
         edge_mem[count_ff[EIDX_W-1:0]] <= ewr_data;
      end
      edata_ff <= edge_mem[idx_ff[EIDX_W-1:0]];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_equivalent = rsp_eq_ff;
   assign rsp_is_verdict = rsp_verdict_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule
